[src/pfrd_pkg.sv]
// ----------------------------------------------------------------------------
// pfrd_pkg: shared definitions for the page framebuffer rectangle drawer
// Command codes, store geometry and the structs passed between modules.
// ----------------------------------------------------------------------------
package pfrd_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int PIX_PER_BYTE = 8;

  // Working width of signed coordinates: holds x + w - 1 for all inputs.
  localparam int CW = 12;

  localparam logic [1:0] CMD_FILL    = 2'd0;
  localparam logic [1:0] CMD_OUTLINE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  // Clipped drawing job. The lo/hi bounds are inclusive and on screen; the
  // edge fields are the unclipped outline rows and columns.
  typedef struct packed {
    logic                 nonempty;
    logic                 outline;
    logic                 on;
    logic signed [CW-1:0] xlo;
    logic signed [CW-1:0] xhi;
    logic signed [CW-1:0] ylo;
    logic signed [CW-1:0] yhi;
    logic signed [CW-1:0] xl;
    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yt;
    logic signed [CW-1:0] yb;
  } job_t;

  // One store operation issued by the scanner.
  typedef struct packed {
    logic                valid;
    logic                clr;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          mask;
    logic                on;
  } op_t;

endpackage

[src/pfrd_ram.sv]
// ----------------------------------------------------------------------------
// pfrd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pfrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pfrd_clip.sv]
// ----------------------------------------------------------------------------
// pfrd_clip: rectangle clipping
// Turns a command beat into an inclusive on-screen bounding box.
// ----------------------------------------------------------------------------
module pfrd_clip #(
  parameter int SCREEN_WIDTH  = pfrd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfrd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic               [1:0] cmd,
  input  logic signed        [9:0] pos_x,
  input  logic signed        [9:0] pos_y,
  input  logic signed        [9:0] rect_w,
  input  logic signed        [9:0] rect_h,
  input  logic                     pixel_on,
  output pfrd_pkg::job_t           job
);

  localparam int CW = pfrd_pkg::CW;
  localparam logic signed [CW-1:0] XMAX = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(SCREEN_HEIGHT - 1);

  logic signed [CW-1:0] x, y, w, h, xe, ye, xlo, xhi, ylo, yhi;

  always_comb begin
    x   = CW'(pos_x);
    y   = CW'(pos_y);
    w   = CW'(rect_w);
    h   = CW'(rect_h);
    xe  = x + w - CW'(1);
    ye  = y + h - CW'(1);
    xlo = (x < 0) ? '0 : x;
    ylo = (y < 0) ? '0 : y;
    xhi = (xe > XMAX) ? XMAX : xe;
    yhi = (ye > YMAX) ? YMAX : ye;

    job.nonempty = (w > 0) && (h > 0) && (xlo <= xhi) && (ylo <= yhi);
    job.outline  = (cmd == pfrd_pkg::CMD_OUTLINE);
    job.on       = pixel_on;
    job.xlo      = xlo;
    job.xhi      = xhi;
    job.ylo      = ylo;
    job.yhi      = yhi;
    job.xl       = x;
    job.xr       = xe;
    job.yt       = y;
    job.yb       = ye;
  end

endmodule

[src/pfrd_scan.sv]
// ----------------------------------------------------------------------------
// pfrd_scan: store address and mask sequencer
// Walks the bytes of a clipped rectangle page by page, or sweeps the whole
// store for a clear, issuing one store operation per cycle.
// ----------------------------------------------------------------------------
module pfrd_scan #(
  parameter int SCREEN_WIDTH  = pfrd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfrd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start_draw,
  input  logic           start_clear,
  input  pfrd_pkg::job_t job,
  output pfrd_pkg::op_t  op,
  output logic           busy
);

  localparam int CW    = pfrd_pkg::CW;
  localparam int AW    = pfrd_pkg::STORE_AW;
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int NPAGE = (SCREEN_HEIGHT + 7) / 8;
  localparam int PW    = (NPAGE > 1) ? $clog2(NPAGE) : 1;
  localparam int RW    = PW + 3;
  localparam int LW    = (PW + XW > AW) ? PW + XW : AW + 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(pfrd_pkg::STORE_DEPTH - 1);

  logic                 clr;
  logic [AW-1:0]        clr_addr;
  logic [XW-1:0]        cur_x, x_first, x_last;
  logic [PW-1:0]        cur_p, p_last;
  logic                 outline, on;
  logic signed [CW-1:0] ylo, yhi, xl, xr, yt, yb;

  logic [7:0]           mask;
  logic [LW-1:0]        addr_full;
  logic                 in_store;
  logic                 col_edge;
  logic signed [CW-1:0] col_s;

  always_comb begin
    logic [RW-1:0]        row;
    logic signed [CW-1:0] row_s;
    logic                 in_range, on_edge;
    col_s    = $signed({{(CW-XW){1'b0}}, cur_x});
    col_edge = (col_s == xl) || (col_s == xr);
    for (int k = 0; k < pfrd_pkg::PIX_PER_BYTE; k++) begin
      row      = {cur_p, 3'(k)};
      row_s    = $signed({{(CW-RW){1'b0}}, row});
      in_range = (row_s >= ylo) && (row_s <= yhi);
      on_edge  = (row_s == yt) || (row_s == yb);
      mask[k]  = (outline && !col_edge) ? (in_range && on_edge) : in_range;
    end
    addr_full = LW'(cur_p) * LW'(SCREEN_WIDTH) + LW'(cur_x);
    in_store  = addr_full < LW'(pfrd_pkg::STORE_DEPTH);

    op.valid = busy && (clr || (in_store && (mask != 8'd0)));
    op.clr   = clr;
    op.addr  = clr ? clr_addr : addr_full[AW-1:0];
    op.mask  = mask;
    op.on    = on;
  end

  // Control state; reset starts the power-up clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr      <= 1'b1;
      clr_addr <= '0;
    end else if (start_clear) begin
      busy     <= 1'b1;
      clr      <= 1'b1;
      clr_addr <= '0;
    end else if (start_draw) begin
      busy <= job.nonempty;
      clr  <= 1'b0;
    end else if (busy) begin
      if (clr) begin
        if (clr_addr == CLR_LAST) begin
          busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end else if ((cur_x == x_last) && (cur_p == p_last)) begin
        busy <= 1'b0;
      end
    end
  end

  // Walk position and job fields.
  always_ff @(posedge clk) begin
    if (start_draw) begin
      cur_x   <= job.xlo[XW-1:0];
      x_first <= job.xlo[XW-1:0];
      x_last  <= job.xhi[XW-1:0];
      cur_p   <= job.ylo[PW+2:3];
      p_last  <= job.yhi[PW+2:3];
      outline <= job.outline;
      on      <= job.on;
      ylo     <= job.ylo;
      yhi     <= job.yhi;
      xl      <= job.xl;
      xr      <= job.xr;
      yt      <= job.yt;
      yb      <= job.yb;
    end else if (busy && !clr) begin
      if (cur_x == x_last) begin
        cur_x <= x_first;
        cur_p <= cur_p + PW'(1);
      end else begin
        cur_x <= cur_x + XW'(1);
      end
    end
  end

endmodule

[src/page_framebuffer_rect_draw.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_rect_draw: paged monochrome framebuffer with rectangles
// Fills, outlines and clears pixels of a page-organized 1024-byte store and
// reads single bytes back. Each command beat returns one result beat.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  --------------------------------------------
//   input    in_valid / in_ready  cmd, pos_x, pos_y, rect_w, rect_h, pixel_on,
//                                 read_index
//   output   out_valid/out_ready  read_data
//
// A fill or outline walks the pages and columns of the clipped box; the store
// is updated one byte per cycle by a read-modify-write over the RAM's read and
// write ports. A clear sweeps all 1024 bytes, one per cycle.
// After reset the block clears the store before in_ready rises.
// A new command is accepted while the previous result beat still waits at the
// output; the block then holds its own result until the output register frees.
//
module page_framebuffer_rect_draw #(
  parameter int SCREEN_WIDTH  = pfrd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfrd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic        [1:0] cmd,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic signed [9:0] rect_w,
  input  logic signed [9:0] rect_h,
  input  logic              pixel_on,
  input  logic        [9:0] read_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic        [7:0] read_data
);

  localparam int AW = pfrd_pkg::STORE_AW;

  // Sequencer states.
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]     state;
  logic           accept;
  logic           start_draw, start_clear;
  pfrd_pkg::job_t job;
  pfrd_pkg::op_t  op;
  logic           scan_busy;

  // Second stage of the read-modify-write.
  logic           s1_valid;
  logic [AW-1:0]  s1_addr;
  logic [7:0]     s1_mask;
  logic           s1_on;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic [7:0]     res_data;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign start_draw  = accept && ((cmd == pfrd_pkg::CMD_FILL) ||
                                  (cmd == pfrd_pkg::CMD_OUTLINE));
  assign start_clear = accept && (cmd == pfrd_pkg::CMD_CLEAR);

  pfrd_clip #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_clip (
    .cmd     (cmd),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .rect_w  (rect_w),
    .rect_h  (rect_h),
    .pixel_on(pixel_on),
    .job     (job)
  );

  pfrd_scan #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start_draw (start_draw),
    .start_clear(start_clear),
    .job        (job),
    .op         (op),
    .busy       (scan_busy)
  );

  // The read port serves either a read command at acceptance or the first
  // half of a read-modify-write. Clear beats write zero without reading.
  // Accesses of one command touch distinct bytes, and a new command is only
  // accepted after the last write-back, so no forwarding is needed.
  always_comb begin
    ram_re    = (accept && (cmd == pfrd_pkg::CMD_READ)) || (op.valid && !op.clr);
    ram_raddr = accept ? read_index : op.addr;
    if (op.clr) begin
      ram_we    = op.valid;
      ram_waddr = op.addr;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = s1_valid;
      ram_waddr = s1_addr;
      ram_wdata = s1_on ? (ram_rdata | s1_mask) : (ram_rdata & ~s1_mask);
    end
  end

  pfrd_ram #(
    .WIDTH(8),
    .DEPTH(pfrd_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= op.valid && !op.clr;
    end
    s1_addr <= op.addr;
    s1_mask <= op.mask;
    s1_on   <= op.on;
  end

  // Command sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      // In the finishing state the register is reloaded below instead.
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          if (!scan_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_data <= 8'd0;
            unique case (cmd)
              pfrd_pkg::CMD_FILL,
              pfrd_pkg::CMD_OUTLINE: state <= ST_DRAW;
              pfrd_pkg::CMD_CLEAR:   state <= ST_CLEAR;
              pfrd_pkg::CMD_READ:    state <= ST_READ;
            endcase
          end
        end
        ST_DRAW, ST_CLEAR: begin
          if (!scan_busy) begin
            state <= ST_FIN;
          end
        end
        ST_READ: begin
          res_data <= ram_rdata;
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            read_data <= res_data;
            state     <= ST_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A command is never taken while the sequencer is still walking the store.
  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !scan_busy)
    else $error("command accepted while store walk busy");

  // Clear writes and read-modify-write write-backs never share the write port.
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (op.valid && op.clr) |-> !s1_valid)
    else $error("clear write collides with write-back");

  // A read command goes straight to capturing the RAM output.
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == pfrd_pkg::CMD_READ)) |=> (state == ST_READ))
    else $error("read command lost its data cycle");

  // A finished result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
    else $error("output register overwritten");
`endif

endmodule
